FILE: rtl/chd_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
package chd_pkg;

    // Field and datapath widths fixed by the sample and result formats.
    localparam int AXIS_W    = 16;
    localparam int HEADING_W = 27;
    localparam int ANGLE_W   = 26;
    localparam int VEC_W     = 27;
    localparam int ACC_W     = 35;
    localparam int TAB_W     = 32;
    localparam int TAB_DEPTH = 32;
    localparam int FRAC_BITS = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DECL_W    = 26;

    // Angle constants in 1e-5 degree, accumulator start in 1e-5/256 degree.
    localparam logic [ANGLE_W-1:0] FULL_TURN      = 26'd36000000;
    localparam logic [ANGLE_W-1:0] ANGLE_WEST     = 26'd17999999;
    localparam logic [ANGLE_W-1:0] ANGLE_NORTH    = 26'd8999999;
    localparam logic [ANGLE_W-1:0] ANGLE_SOUTH    = 26'd27000001;
    localparam logic [ACC_W-1:0]   QUARTER_TURN_Z = 35'd2304000000;
    localparam logic [9:0]         DECL_SCALE     = 10'd1000;

    // atan(2^-i) in 1e-5/256 degree, rounded to nearest.
    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_DEPTH] = '{
        32'd1152000000, 32'd680065310, 32'd359327833, 32'd182400419,
        32'd91554160,   32'd45821712,  32'd22916447,  32'd11458923,
        32'd5729549,    32'd2864785,   32'd1432394,   32'd716197,
        32'd358099,     32'd179049,    32'd89525,     32'd44762,
        32'd22381,      32'd11191,     32'd5595,      32'd2798,
        32'd1399,       32'd699,       32'd350,       32'd175,
        32'd87,         32'd44,        32'd22,        32'd11,
        32'd5,          32'd3,         32'd1,         32'd1
    };

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET    = 2'd0,
        REG_Y_OFFSET    = 2'd1,
        REG_DECLINATION = 2'd2
    } cfg_reg_t;

    // How the final angle is formed: by the CORDIC or by an axis shortcut.
    typedef enum logic [2:0] {
        ANG_CORDIC = 3'd0,
        ANG_ZERO   = 3'd1,
        ANG_WEST   = 3'd2,
        ANG_NORTH  = 3'd3,
        ANG_SOUTH  = 3'd4
    } ang_code_t;

endpackage

FILE: rtl/chd_if.sv
// Valid/ready channel interfaces for magnetometer samples and heading results.
interface chd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [chd_pkg::AXIS_W-1:0]    x_raw;
    logic signed [chd_pkg::AXIS_W-1:0]    y_raw;

    modport source (output valid, output x_raw, output y_raw, input ready);
    modport sink   (input valid, input x_raw, input y_raw, output ready);
endinterface

interface chd_out_if;
    logic                              valid;
    logic                              ready;
    logic [chd_pkg::HEADING_W-1:0]     heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

FILE: rtl/compass_heading_atan2.sv
// Compass heading: one sample transaction per clock unless the result is stalled.
// Samples pass through the CORDIC pipeline, which spends one register stage on
// each vectoring iteration, plus one stage for offset correction and quadrant
// pre-rotation, one for scaling and wrapping the angle, and the output register
// that adds the declination. Each stage holds only while its successor is full
// and stalled, so bubbles are squeezed out and the input stays ready while a
// finished heading waits, until all CORDIC_STEPS + 3 stages are full. Configuration
// writes take effect at once and are meant for idle periods.
module compass_heading_atan2 #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    chd_in_if.sink                          sample,
    chd_out_if.source                       result,
    input  logic                            wr_en,
    input  logic [chd_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [chd_pkg::AXIS_W-1:0]      wr_data
);

    localparam int NST    = CORDIC_STEPS + 3;
    localparam int ST_ANG = CORDIC_STEPS + 1;
    localparam int ST_OUT = CORDIC_STEPS + 2;
    localparam int VW     = chd_pkg::VEC_W;
    localparam int ZW     = chd_pkg::ACC_W;

    // Configuration registers; declination is kept already scaled by 1000.
    logic [chd_pkg::AXIS_W-1:0] x_offset_reg;
    logic [chd_pkg::AXIS_W-1:0] y_offset_reg;
    logic [chd_pkg::DECL_W-1:0] decl_scaled_reg;

    // Pipeline valid bits and per-stage advance enables.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] stage_en;

    // CORDIC vector, accumulator and angle code per stage.
    logic signed [VW-1:0]   x_reg    [CORDIC_STEPS+1];
    logic signed [VW-1:0]   y_reg    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   z_reg    [CORDIC_STEPS+1];
    chd_pkg::ang_code_t     code_reg [CORDIC_STEPS+1];
    logic signed [VW-1:0]   x_next   [CORDIC_STEPS+1];
    logic signed [VW-1:0]   y_next   [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   z_next   [CORDIC_STEPS+1];
    logic signed [VW-1:0]   x0_next;
    logic signed [VW-1:0]   y0_next;
    logic signed [ZW-1:0]   z0_next;
    chd_pkg::ang_code_t     code_next;

    logic [chd_pkg::ANGLE_W-1:0]   angle_reg;
    logic [chd_pkg::ANGLE_W-1:0]   angle_next;
    logic [chd_pkg::HEADING_W-1:0] heading_reg;
    logic [chd_pkg::HEADING_W-1:0] heading_next;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
            decl_scaled_reg <= '0;
        end
        else if (wr_en)
        begin
            case (chd_pkg::cfg_reg_t'(wr_index))
                chd_pkg::REG_X_OFFSET:    x_offset_reg <= wr_data;
                chd_pkg::REG_Y_OFFSET:    y_offset_reg <= wr_data;
                chd_pkg::REG_DECLINATION:
                    decl_scaled_reg <= chd_pkg::DECL_W'(wr_data) *
                                       chd_pkg::DECL_W'(chd_pkg::DECL_SCALE);
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or when the stage after it advances.
    always_comb
    begin
        stage_en[NST-1] = !valid_reg[NST-1] || result.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign sample.ready = stage_en[0];
    assign result.valid = valid_reg[ST_OUT];
    assign result.heading = heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Entry stage: offset correction, axis shortcuts and quadrant pre-rotation.
    always_comb
    begin
        logic signed [chd_pkg::AXIS_W-1:0] xs;
        logic signed [chd_pkg::AXIS_W-1:0] ys;
        logic signed [VW-1:0]              xw;
        logic signed [VW-1:0]              yw;

        xs = signed'(chd_pkg::AXIS_W'(sample.x_raw + x_offset_reg));
        ys = signed'(chd_pkg::AXIS_W'(sample.y_raw + y_offset_reg));
        xw = {{(VW - chd_pkg::AXIS_W - chd_pkg::FRAC_BITS){xs[chd_pkg::AXIS_W-1]}},
              xs, {chd_pkg::FRAC_BITS{1'b0}}};
        yw = {{(VW - chd_pkg::AXIS_W - chd_pkg::FRAC_BITS){ys[chd_pkg::AXIS_W-1]}},
              ys, {chd_pkg::FRAC_BITS{1'b0}}};

        if (ys == '0)
        begin
            code_next = (xs < 0) ? chd_pkg::ANG_WEST : chd_pkg::ANG_ZERO;
        end
        else if (xs == '0)
        begin
            code_next = (ys > 0) ? chd_pkg::ANG_NORTH : chd_pkg::ANG_SOUTH;
        end
        else
        begin
            code_next = chd_pkg::ANG_CORDIC;
        end

        // Left half plane: turn by a quarter so the iterations converge.
        if (xw < 0)
        begin
            if (yw >= 0)
            begin
                x0_next = yw;
                y0_next = -xw;
                z0_next = signed'(chd_pkg::QUARTER_TURN_Z);
            end
            else
            begin
                x0_next = -yw;
                y0_next = xw;
                z0_next = -signed'(chd_pkg::QUARTER_TURN_Z);
            end
        end
        else
        begin
            x0_next = xw;
            y0_next = yw;
            z0_next = '0;
        end
    end

    // One vectoring iteration per stage, shift and table entry fixed per stage.
    always_comb
    begin
        logic signed [ZW-1:0] t;
        x_next[0] = x0_next;
        y_next[0] = y0_next;
        z_next[0] = z0_next;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            t = signed'(ZW'(chd_pkg::ATAN_TAB[5'(k)]));
            if (y_reg[k] >= 0)
            begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + t;
            end
            else
            begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - t;
            end
        end
    end

    // Angle stage: drop the fraction toward zero, wrap negatives, apply shortcuts.
    always_comb
    begin
        logic [ZW-1:0]                z_abs;
        logic [chd_pkg::ANGLE_W-1:0]  q_mag;
        logic                         z_neg;

        z_neg = z_reg[CORDIC_STEPS][ZW-1];
        z_abs = z_neg ? ZW'(-z_reg[CORDIC_STEPS]) : ZW'(z_reg[CORDIC_STEPS]);
        q_mag = chd_pkg::ANGLE_W'(z_abs >> chd_pkg::FRAC_BITS);

        case (code_reg[CORDIC_STEPS])
            chd_pkg::ANG_CORDIC:
            begin
                if (z_neg && (q_mag != '0))
                begin
                    angle_next = chd_pkg::FULL_TURN - q_mag;
                end
                else
                begin
                    angle_next = q_mag;
                end
            end
            chd_pkg::ANG_WEST:  angle_next = chd_pkg::ANGLE_WEST;
            chd_pkg::ANG_NORTH: angle_next = chd_pkg::ANGLE_NORTH;
            chd_pkg::ANG_SOUTH: angle_next = chd_pkg::ANGLE_SOUTH;
            default:            angle_next = '0;
        endcase
    end

    // Output stage: add the scaled declination.
    assign heading_next = chd_pkg::HEADING_W'(angle_reg) +
                          chd_pkg::HEADING_W'(decl_scaled_reg);

    // Payload registers follow their stage enables.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= CORDIC_STEPS; k++)
        begin
            if (stage_en[k])
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
        if (stage_en[0])
        begin
            code_reg[0] <= code_next;
        end
        for (int k = 1; k <= CORDIC_STEPS; k++)
        begin
            if (stage_en[k])
            begin
                code_reg[k] <= code_reg[k-1];
            end
        end
        if (stage_en[ST_ANG])
        begin
            angle_reg <= angle_next;
        end
        if (stage_en[ST_OUT])
        begin
            heading_reg <= heading_next;
        end
    end

endmodule

FILE: rtl/chd_checker.sv
// Port-level checker for the compass heading block, bound to the top level.
module chd_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [chd_pkg::HEADING_W-1:0]     heading
);

    localparam int NST = CORDIC_STEPS + 3;
    localparam int CW  = $clog2(NST + 1) + 1;

    logic          in_fire;
    logic          out_fire;
    logic [CW-1:0] inflight_reg;
    logic [CW-1:0] inflight_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Count of transactions accepted but not yet delivered.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_fire && !out_fire)
        begin
            inflight_next = inflight_reg + CW'(1);
        end
        else if (out_fire && !in_fire)
        begin
            inflight_next = inflight_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result is only offered for a transaction that was accepted earlier.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inflight_reg != '0))
        else $error("result offered with no transaction in flight");

    // The pipeline never holds more transactions than it has stages.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CW'(NST))
        else $error("more transactions in flight than pipeline stages");

    // With the output register empty the whole pipeline can move.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register is empty");

    // The heading never exceeds a full turn plus the largest declination.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading <= 27'd101534999))
        else $error("heading out of range");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(heading)))
        else $error("stalled result changed or dropped");

endmodule

bind compass_heading_atan2 chd_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_chd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .heading   (result.heading)
);
